// ===== hdl/direct_mapped_tlb_macros.svh =====
// assertion macros for the direct-mapped translation buffer
// expects clk and rst_n in the scope of every module that uses them
`ifndef DIRECT_MAPPED_TLB_MACROS_SVH
`define DIRECT_MAPPED_TLB_MACROS_SVH

// same-cycle implication, disabled during reset
`define DMTLB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define DMTLB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/dmtlb_pkg.sv =====
// shared types and constants of the direct-mapped translation buffer
// no dependencies
`default_nettype none

package dmtlb_pkg;

    localparam int ADDR_W  = 32;
    localparam int FRAME_W = 20;
    localparam int CNT_W   = 32;
    localparam int CMD_W   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_FILL   = 2'd1,
        CMD_INVAL  = 2'd2
    } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/dmtlb_if.sv =====
// request and response channel interfaces of the translation buffer
// depends on dmtlb_pkg
`default_nettype none

interface dmtlb_req_if;
    import dmtlb_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [ADDR_W-1:0]  vaddr;
    logic [FRAME_W-1:0] fill_frame;

    modport source (output valid, output cmd, output vaddr, output fill_frame, input ready);
    modport sink   (input valid, input cmd, input vaddr, input fill_frame, output ready);
endinterface

interface dmtlb_rsp_if;
    import dmtlb_pkg::*;

    logic               valid;
    logic               ready;
    logic               hit;
    logic [FRAME_W-1:0] frame_out;
    logic [CNT_W-1:0]   lookups_total;
    logic [CNT_W-1:0]   misses_total;

    modport source (output valid, output hit, output frame_out, output lookups_total,
                    output misses_total, input ready);
    modport sink   (input valid, input hit, input frame_out, input lookups_total,
                    input misses_total, output ready);
endinterface

`default_nettype wire

// ===== hdl/direct_mapped_tlb.sv =====
// top level of the direct-mapped translation buffer
// depends on dmtlb_pkg, dmtlb_if, dmtlb_store and dmtlb_core
`default_nettype none

// Direct-mapped translation buffer. Each request transaction carries a command
// (lookup, fill or invalidate), a 32-bit virtual address and a fill frame; each one
// produces exactly one response transaction with hit, frame_out and the running
// lookup and miss counts. The virtual page number is vaddr above PAGE_OFFSET_BITS
// and is stored whole as the tag; the entry index is its low floor(log2(ENTRIES))
// bits. There is no valid bit: tags clear to zero, so page zero can hit with frame
// zero after reset. Throughput is one transaction per cycle while rsp.ready is high
// and the clearing sweep is done. The memory read is registered when the request is
// accepted; the compare, entry write-back and counter update happen as the command
// moves on into the response register. A write to the entry being read in the same
// cycle is forwarded into the read register, so back-to-back commands to one entry
// see each other. After reset the block sweeps all 2**floor(log2(ENTRIES)) entries
// (512 by default) to zero, one entry per cycle, with req.ready low.
// The response register lets a new request enter while an older response waits.
module direct_mapped_tlb #(
    parameter int ENTRIES          = 512,
    parameter int PAGE_OFFSET_BITS = 12
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    dmtlb_req_if.sink   req,
    dmtlb_rsp_if.source rsp
);
    import dmtlb_pkg::*;

    // index bits: log2 of the largest power of two not above ENTRIES
    localparam int IDX_W = $clog2(ENTRIES + 1) - 1;
    localparam int TAG_W = ADDR_W - PAGE_OFFSET_BITS;

    logic               busy;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_idx;
    logic [TAG_W-1:0]   rd_tag;
    logic [FRAME_W-1:0] rd_frame;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    logic [TAG_W-1:0]   wr_tag;
    logic [FRAME_W-1:0] wr_frame;

    // tag and frame memory
    dmtlb_store #(
        .IDX_W (IDX_W),
        .TAG_W (TAG_W)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_idx   (rd_idx),
        .rd_tag   (rd_tag),
        .rd_frame (rd_frame),
        .wr_en    (wr_en),
        .wr_idx   (wr_idx),
        .wr_tag   (wr_tag),
        .wr_frame (wr_frame),
        .busy     (busy)
    );

    // command decode, compare, counters and response register
    dmtlb_core #(
        .PAGE_OFFSET_BITS (PAGE_OFFSET_BITS),
        .IDX_W            (IDX_W),
        .TAG_W            (TAG_W)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .busy     (busy),
        .rd_en    (rd_en),
        .rd_idx   (rd_idx),
        .rd_tag   (rd_tag),
        .rd_frame (rd_frame),
        .wr_en    (wr_en),
        .wr_idx   (wr_idx),
        .wr_tag   (wr_tag),
        .wr_frame (wr_frame)
    );

endmodule

`default_nettype wire

// ===== hdl/dmtlb_store.sv =====
// tag and frame memory with registered read, write-first bypass and reset clearing sweep
// depends on dmtlb_pkg
`default_nettype none

module dmtlb_store #(
    parameter int IDX_W = 9,
    parameter int TAG_W = 20
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          rd_en,
    input  wire logic [IDX_W-1:0]              rd_idx,
    output logic      [TAG_W-1:0]              rd_tag,
    output logic      [dmtlb_pkg::FRAME_W-1:0] rd_frame,
    input  wire logic                          wr_en,
    input  wire logic [IDX_W-1:0]              wr_idx,
    input  wire logic [TAG_W-1:0]              wr_tag,
    input  wire logic [dmtlb_pkg::FRAME_W-1:0] wr_frame,
    output logic                               busy
);
    import dmtlb_pkg::*;

    localparam int SLOTS = 1 << IDX_W;

    logic [TAG_W-1:0]   tag_mem [SLOTS];
    logic [FRAME_W-1:0] frame_mem [SLOTS];

    logic               clearing_reg;
    logic               clearing_next;
    logic [IDX_W-1:0]   clr_idx_reg;
    logic [IDX_W-1:0]   clr_idx_next;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_wa;
    logic [TAG_W-1:0]   mem_wtag;
    logic [FRAME_W-1:0] mem_wframe;
    logic               bypass;

    logic [TAG_W-1:0]   rd_tag_reg;
    logic [FRAME_W-1:0] rd_frame_reg;

    // clearing sweep after reset, one entry a cycle
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_idx_next  = clr_idx_reg;
        if (clearing_reg)
        begin
            clr_idx_next = clr_idx_reg + IDX_W'(1);
            if (clr_idx_reg == {IDX_W{1'b1}})
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_idx_reg  <= clr_idx_next;
        end
    end

    assign mem_we     = clearing_reg || wr_en;
    assign mem_wa     = clearing_reg ? clr_idx_reg : wr_idx;
    assign mem_wtag   = clearing_reg ? '0 : wr_tag;
    assign mem_wframe = clearing_reg ? '0 : wr_frame;
    assign bypass     = wr_en && (wr_idx == rd_idx);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tag_mem[mem_wa]   <= mem_wtag;
            frame_mem[mem_wa] <= mem_wframe;
        end
    end

    // a write in the same cycle to the same entry wins over the stored value
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_tag_reg   <= bypass ? wr_tag   : tag_mem[rd_idx];
            rd_frame_reg <= bypass ? wr_frame : frame_mem[rd_idx];
        end
    end

    assign rd_tag   = rd_tag_reg;
    assign rd_frame = rd_frame_reg;
    assign busy     = clearing_reg;

endmodule

`default_nettype wire

// ===== hdl/dmtlb_core.sv =====
// command stage: tag compare, entry update, counters and result register
// depends on dmtlb_pkg, dmtlb_if and direct_mapped_tlb_macros.svh
`default_nettype none

`include "direct_mapped_tlb_macros.svh"

module dmtlb_core #(
    parameter int PAGE_OFFSET_BITS = 12,
    parameter int IDX_W            = 9,
    parameter int TAG_W            = 20
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    dmtlb_req_if.sink                          req,
    dmtlb_rsp_if.source                        rsp,
    input  wire logic                          busy,
    output logic                               rd_en,
    output logic      [IDX_W-1:0]              rd_idx,
    input  wire logic [TAG_W-1:0]              rd_tag,
    input  wire logic [dmtlb_pkg::FRAME_W-1:0] rd_frame,
    output logic                               wr_en,
    output logic      [IDX_W-1:0]              wr_idx,
    output logic      [TAG_W-1:0]              wr_tag,
    output logic      [dmtlb_pkg::FRAME_W-1:0] wr_frame
);
    import dmtlb_pkg::*;

    logic               accept;
    logic               a_adv;

    logic               a_valid_reg;
    logic               a_valid_next;
    cmd_t               a_cmd_reg;
    logic [TAG_W-1:0]   a_vpn_reg;
    logic [FRAME_W-1:0] a_frame_reg;

    logic               match;
    logic               do_write;
    logic [FRAME_W-1:0] frame_sel;

    logic [CNT_W-1:0]   lk_reg;
    logic [CNT_W-1:0]   lk_next;
    logic [CNT_W-1:0]   miss_reg;
    logic [CNT_W-1:0]   miss_next;

    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    logic               hit_reg;
    logic [FRAME_W-1:0] frame_out_reg;

    assign a_adv     = a_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !busy && (!a_valid_reg || a_adv);
    assign accept    = req.valid && req.ready;

    assign rd_en  = accept;
    assign rd_idx = req.vaddr[PAGE_OFFSET_BITS +: IDX_W];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_cmd_reg   <= cmd_t'(req.cmd);
            a_vpn_reg   <= req.vaddr[ADDR_W-1:PAGE_OFFSET_BITS];
            a_frame_reg <= req.fill_frame;
        end
    end

    assign match  = (rd_tag == a_vpn_reg);
    assign wr_idx = a_vpn_reg[IDX_W-1:0];
    assign wr_en  = do_write && a_adv;

    always_comb
    begin
        do_write  = 1'b0;
        wr_tag    = a_vpn_reg;
        wr_frame  = a_frame_reg;
        frame_sel = '0;
        lk_next   = lk_reg;
        miss_next = miss_reg;
        unique case (a_cmd_reg)
            CMD_LOOKUP:
            begin
                lk_next = lk_reg + CNT_W'(1);
                if (match)
                begin
                    frame_sel = rd_frame;
                end
                else
                begin
                    miss_next = miss_reg + CNT_W'(1);
                end
            end
            CMD_FILL:
            begin
                do_write = 1'b1;
            end
            CMD_INVAL:
            begin
                if (match)
                begin
                    do_write = 1'b1;
                    wr_tag   = '0;
                    wr_frame = '0;
                end
            end
            default:
            begin
                do_write = 1'b0;
            end
        endcase
    end

    assign a_valid_next   = accept || (a_valid_reg && !a_adv);
    assign rsp_valid_next = a_adv || (rsp_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
            lk_reg        <= '0;
            miss_reg      <= '0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (a_adv)
            begin
                lk_reg   <= lk_next;
                miss_reg <= miss_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            hit_reg       <= match;
            frame_out_reg <= frame_sel;
        end
    end

    // counters only move when a result is loaded, so they match the held result
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.hit           = hit_reg;
    assign rsp.frame_out     = frame_out_reg;
    assign rsp.lookups_total = lk_reg;
    assign rsp.misses_total  = miss_reg;

    `DMTLB_ASSERT_NEXT(a_non_lookup_keeps_counters, a_adv && (a_cmd_reg != CMD_LOOKUP), $stable(lk_reg) && $stable(miss_reg), "counter changed on non-lookup")
    `DMTLB_ASSERT_NEXT(a_miss_counted, a_adv && (a_cmd_reg == CMD_LOOKUP) && !match, miss_reg == ($past(miss_reg) + CNT_W'(1)), "lookup miss not counted")
    `DMTLB_ASSERT_NOW(a_frame_needs_hit, rsp_valid_reg && (frame_out_reg != '0), hit_reg, "frame returned without hit")
    `DMTLB_ASSERT_NEXT(a_stalled_item_holds, a_valid_reg && !a_adv, a_valid_reg && $stable(a_vpn_reg), "stalled command lost")
    `DMTLB_ASSERT_NOW(a_no_accept_while_clearing, busy, !accept && !wr_en, "activity during clearing")

endmodule

`default_nettype wire

// ===== tb/dmtlb_checker_pkg.sv =====
// transaction types and the self-checking scoreboard for the translation buffer bench
// depends on dmtlb_pkg
package dmtlb_checker_pkg;
    import dmtlb_pkg::*;

    // must match the parameters given to the block under test
    localparam int ENTRIES          = 512;
    localparam int PAGE_OFFSET_BITS = 12;
    localparam int VPN_W            = ADDR_W - PAGE_OFFSET_BITS;
    localparam int INDEX_W          = $clog2(ENTRIES);

    // the two-bit command field has one code with no command behind it
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [ADDR_W-1:0]  vaddr;
        logic [FRAME_W-1:0] fill_frame;
    } tlb_request_t;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame_out;
        logic [CNT_W-1:0]   lookups_total;
        logic [CNT_W-1:0]   misses_total;
    } tlb_result_t;

    class tlb_checker;
        bit [VPN_W-1:0]   tag_mem [ENTRIES];
        bit [FRAME_W-1:0] frame_mem [ENTRIES];
        bit [CNT_W-1:0]   lookup_count;
        bit [CNT_W-1:0]   miss_count;
        tlb_result_t      translations_due [$];
        int               failures;
        int               checked;

        // apply one accepted request to the shadow entries and queue its response
        function void note_request(tlb_request_t item);
            bit [VPN_W-1:0]   vpn;
            bit [INDEX_W-1:0] slot;
            bit               match;
            tlb_result_t      due;
            vpn   = item.vaddr[ADDR_W-1:PAGE_OFFSET_BITS];
            slot  = vpn[INDEX_W-1:0];
            match = (tag_mem[slot] == vpn);
            due.hit       = match;
            due.frame_out = '0;
            case (item.cmd)
                CMD_LOOKUP:
                begin
                    lookup_count++;
                    if (match)
                        due.frame_out = frame_mem[slot];
                    else
                        miss_count++;
                end
                CMD_FILL:
                begin
                    tag_mem[slot]   = vpn;
                    frame_mem[slot] = item.fill_frame;
                end
                CMD_INVAL:
                begin
                    if (match)
                    begin
                        tag_mem[slot]   = '0;
                        frame_mem[slot] = '0;
                    end
                end
                default: ;
            endcase
            due.lookups_total = lookup_count;
            due.misses_total  = miss_count;
            translations_due.push_back(due);
        endfunction

        function void check_response(tlb_result_t seen);
            tlb_result_t due;
            if (translations_due.size() == 0)
            begin
                $error("response transaction with no request outstanding");
                failures++;
                return;
            end
            due = translations_due.pop_front();
            checked++;
            if (seen.hit !== due.hit)
            begin
                $error("hit: expected %0d, got %0d", due.hit, seen.hit);
                failures++;
            end
            if (seen.frame_out !== due.frame_out)
            begin
                $error("frame_out: expected 0x%05h, got 0x%05h", due.frame_out, seen.frame_out);
                failures++;
            end
            if (seen.lookups_total !== due.lookups_total)
            begin
                $error("lookups_total: expected %0d, got %0d",
                       due.lookups_total, seen.lookups_total);
                failures++;
            end
            if (seen.misses_total !== due.misses_total)
            begin
                $error("misses_total: expected %0d, got %0d",
                       due.misses_total, seen.misses_total);
                failures++;
            end
        endfunction

        function int outstanding();
            return translations_due.size();
        endfunction
    endclass

endpackage

// ===== tb/direct_mapped_tlb_test.sv =====
// top of the translation buffer bench: clock, reset, request driver, response sink
// depends on dmtlb_pkg, dmtlb_if, dmtlb_checker_pkg and direct_mapped_tlb
module direct_mapped_tlb_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dmtlb_pkg::*;
    import dmtlb_checker_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 12;
    localparam int RANDOM_ITEMS    = 1230;
    localparam int POOL_SIZE       = 24;
    // the long receiver hold-off starts once this many responses were checked
    localparam int HOLD_OFF_AFTER  = 500;
    localparam int HOLD_OFF_CYCLES = 300;
    // the post-reset sweep and the hold-off both fit well inside this
    localparam int STALL_LIMIT     = 4000;
    localparam int DRAIN_CYCLES    = 8;

    // directed transactions, sent back to back so that commands to one entry
    // follow each other directly whenever the block keeps ready high
    localparam tlb_request_t DIRECTED_REQUESTS [23] = '{
        '{CMD_LOOKUP, 32'h0000_0000, 20'h00000},  // page zero hits right after reset
        '{CMD_LOOKUP, 32'hFFFF_FFFF, 20'hFFFFF},  // top page misses
        '{CMD_FILL,   32'hFFFF_FFFF, 20'hFFFFF},  // fill top entry with the largest frame
        '{CMD_LOOKUP, 32'hFFFF_F000, 20'h00000},  // hit right behind the fill
        '{CMD_UNUSED, 32'hFFFF_F123, 20'h12345},  // unused command on a matching tag
        '{CMD_UNUSED, 32'h0000_1000, 20'h00000},  // unused command on a mismatch
        '{CMD_INVAL,  32'h7FFF_F000, 20'h00000},  // same index, other tag: no effect
        '{CMD_LOOKUP, 32'hFFFF_F800, 20'h00000},  // entry survived
        '{CMD_INVAL,  32'hFFFF_F000, 20'h00000},  // matching invalidate clears it
        '{CMD_LOOKUP, 32'hFFFF_F000, 20'h00000},  // now a miss
        '{CMD_LOOKUP, 32'h0000_0FFF, 20'h00000},  // page zero still hits
        '{CMD_LOOKUP, 32'h001F_F000, 20'h00000},  // cleared tag is zero, not this page
        '{CMD_FILL,   32'h0000_0000, 20'hABCDE},  // give page zero a real frame
        '{CMD_LOOKUP, 32'h0000_0ABC, 20'h00000},
        '{CMD_FILL,   32'h0020_0000, 20'h00000},  // collides with page zero, frame zero
        '{CMD_LOOKUP, 32'h0000_0000, 20'h00000},  // page zero evicted
        '{CMD_LOOKUP, 32'h0020_0FFF, 20'hFFFFF},  // hit with frame zero
        '{CMD_FILL,   32'h1234_5678, 20'h55555},
        '{CMD_FILL,   32'h1234_5000, 20'hAAAAA},  // overwrite the same entry
        '{CMD_LOOKUP, 32'h1234_5FFF, 20'h00000},
        '{CMD_INVAL,  32'h1234_5000, 20'h00000},
        '{CMD_INVAL,  32'h1234_5000, 20'h00000},  // second invalidate finds tag zero
        '{CMD_UNUSED, 32'h0000_0000, 20'hFFFFF}   // unused command, page zero evicted
    };

    logic clk = 1'b0;
    logic rst_n;

    dmtlb_req_if req_ch ();
    dmtlb_rsp_if rsp_ch ();

    tlb_checker sb = new();

    // small set of pages sharing a few indexes, so fills, hits and evictions meet
    bit [VPN_W-1:0] page_pool [POOL_SIZE];

    direct_mapped_tlb #(
        .ENTRIES          (ENTRIES),
        .PAGE_OFFSET_BITS (PAGE_OFFSET_BITS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void refresh_pages();
        bit [INDEX_W-1:0] slots [6];
        foreach (slots[i])
            slots[i] = INDEX_W'($urandom);
        foreach (page_pool[i])
            page_pool[i] = {(VPN_W - INDEX_W)'($urandom), slots[$urandom_range(0, 5)]};
        // keep page zero in play, it starts out as a hit
        page_pool[0] = '0;
    endfunction

    function automatic tlb_request_t random_request();
        tlb_request_t item;
        int           r;
        r = $urandom_range(0, 99);
        if (r < 45)
            item.cmd = CMD_LOOKUP;
        else if (r < 75)
            item.cmd = CMD_FILL;
        else if (r < 95)
            item.cmd = CMD_INVAL;
        else
            item.cmd = CMD_UNUSED;
        // most addresses come from the pool, the rest anywhere in the space
        if ($urandom_range(0, 3) != 0)
            item.vaddr = {page_pool[$urandom_range(0, POOL_SIZE - 1)],
                          PAGE_OFFSET_BITS'($urandom)};
        else
            item.vaddr = $urandom;
        item.fill_frame = FRAME_W'($urandom);
        return item;
    endfunction

    // offer one request and hold it until the block takes it
    task automatic send_request(input tlb_request_t item);
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= item.cmd;
        req_ch.vaddr      <= item.vaddr;
        req_ch.fill_frame <= item.fill_frame;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(item);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // request side: reset, directed transactions, then random traffic
    initial
    begin : request_source
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.cmd        = CMD_LOOKUP;
        req_ch.vaddr      = '0;
        req_ch.fill_frame = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // block clears its entries after reset with ready low, the handshake waits it out
        foreach (DIRECTED_REQUESTS[i])
            send_request(DIRECTED_REQUESTS[i]);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 250 == 0)
                refresh_pages();
            send_request(random_request());
            // every 300 transactions a stretch with no gaps at all
            idle_sender(((n % 300) < 60) ? 0 : pick_gap());
        end
        req_ch.valid <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.failures == 0)
            $display("** direct_mapped_tlb: PASSED **");
        else
            $display("** direct_mapped_tlb: FAILED **");
        $finish;
    end

    // response side: random ready, with one long hold-off that backs the block up
    initial
    begin : response_sink
        int run_len;
        int stall_len;
        bit held_off;
        held_off     = 1'b0;
        rsp_ch.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            run_len = $urandom_range(1, 40);
            rsp_ch.ready <= 1'b1;
            repeat (run_len) @(posedge clk);
            if (!held_off && sb.checked >= HOLD_OFF_AFTER)
            begin
                // the sender keeps offering meanwhile, so the request side stalls
                held_off  = 1'b1;
                stall_len = HOLD_OFF_CYCLES;
            end
            else
                stall_len = pick_gap();
            if (stall_len > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall_len) @(posedge clk);
            end
        end
    end

    // every response transaction is checked against the oldest prediction
    always @(posedge clk)
    begin
        if (rsp_ch.valid && rsp_ch.ready)
            sb.check_response('{rsp_ch.hit, rsp_ch.frame_out,
                                rsp_ch.lookups_total, rsp_ch.misses_total});
    end

    // ends the run if no transaction moves on either channel for too long
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $error("no transaction for %0d cycles, %0d responses outstanding",
               STALL_LIMIT, sb.outstanding());
        $display("** direct_mapped_tlb: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/dmtlb_pkg.sv
hdl/dmtlb_if.sv
hdl/dmtlb_store.sv
hdl/dmtlb_core.sv
hdl/direct_mapped_tlb.sv
tb/dmtlb_checker_pkg.sv
tb/direct_mapped_tlb_test.sv
